/* rtl/shra_pkg.sv */
// Shared types and constants for the sample history ring with aggregate query.
// Holds the controller states, the aggregate mode codes, the register indexes and
// the command and status structs between the controller and the datapath. It has no dependencies.
package shra_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    localparam int VALUE_BITS     = 32;
    localparam int SEQ_BITS       = 32;
    localparam int HIST_LEN_BITS  = 7;
    localparam int MODE_BITS      = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 7;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HISTORY_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AGGREGATE_MODE = 1'd1;

    localparam logic FUNC_PUT   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ALL = 2'd0,
        MODE_AVG = 2'd1,
        MODE_MIN = 2'd2,
        MODE_MAX = 2'd3
    } agg_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_ACCUM,
        ST_EMIT,
        ST_DIV_GO,
        ST_DIV,
        ST_EMIT_AGG,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic store_put;
        logic query_start;
        logic rd_issue;
        logic accum;
        logic ptr_advance;
        logic div_start;
        logic load_list;
        logic load_agg;
        logic load_empty;
    } dp_cmd_t;

    typedef struct packed {
        logic      held_zero;
        logic      last_entry;
        logic      div_done;
        logic      out_free;
        agg_mode_t mode;
    } dp_status_t;

endpackage

/* rtl/shra_div.sv */
// Restoring divider, one quotient bit per cycle, used for the history average.
// Depends on shra_pkg for the divisor width.
module shra_div #(
    parameter int SUM_BITS = 39
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [SUM_BITS-1:0]                dividend,
    input  logic [shra_pkg::HIST_LEN_BITS-1:0] divisor,
    output logic [SUM_BITS-1:0]                quotient,
    output logic                               done
);
    import shra_pkg::*;

    localparam int STEP_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(SUM_BITS - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [SUM_BITS-1:0]      quo_reg, quo_next;
    logic [HIST_LEN_BITS-1:0] rem_reg, rem_next;
    logic [HIST_LEN_BITS:0]   rem_shift;
    logic [HIST_LEN_BITS:0]   rem_diff;
    logic                     fits;

    assign rem_shift = {rem_reg, quo_reg[SUM_BITS-1]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[SUM_BITS-2:0], fits};
            rem_next  = fits ? rem_diff[HIST_LEN_BITS-1:0] : rem_shift[HIST_LEN_BITS-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

/* rtl/shra_dp.sv */
// Datapath: registers, ring memory, read pointer, accumulators and output register.
// Depends on shra_pkg and instantiates shra_div for the average.
module shra_dp #(
    parameter int DEPTH       = shra_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = shra_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [shra_pkg::CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [shra_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic [shra_pkg::VALUE_BITS-1:0]     s_sample,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [shra_pkg::VALUE_BITS-1:0]     m_value,
    output logic [shra_pkg::SEQ_BITS-1:0]       m_first_seq,
    output logic [shra_pkg::HIST_LEN_BITS-1:0]  m_held_count,
    output logic                                m_last,
    input  shra_pkg::dp_cmd_t                   cmd,
    output shra_pkg::dp_status_t                status
);
    import shra_pkg::*;

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_BITS = SAMPLE_BITS + HIST_LEN_BITS;
    localparam logic [HIST_LEN_BITS-1:0] DEPTH_L = HIST_LEN_BITS'(DEPTH);

    // configuration and store state
    logic [HIST_LEN_BITS-1:0] hist_len_reg;
    agg_mode_t                mode_reg;
    logic [IDX_BITS-1:0]      wi_reg, wi_next;
    logic                     wrapped_reg, wrapped_next;
    logic [SEQ_BITS-1:0]      seq_reg, seq_next;

    // query walk state
    logic [IDX_BITS-1:0]      rp_reg, rp_next;
    logic [HIST_LEN_BITS-1:0] k_reg, k_next;
    logic [HIST_LEN_BITS-1:0] held_reg;
    logic [SEQ_BITS-1:0]      fs_reg;
    logic [SUM_BITS-1:0]      sum_reg;
    logic [SAMPLE_BITS-1:0]   min_reg, max_reg;

    logic [SAMPLE_BITS-1:0]   mem [DEPTH];
    logic [SAMPLE_BITS-1:0]   mem_q;

    logic                     m_valid_reg;
    logic [VALUE_BITS-1:0]    m_value_reg;
    logic [SEQ_BITS-1:0]      m_fs_reg;
    logic [HIST_LEN_BITS-1:0] m_held_reg;
    logic                     m_last_reg;

    logic [HIST_LEN_BITS-1:0] len;
    logic [HIST_LEN_BITS-1:0] wi_ext, wi_inc, rp_inc, held_now;
    logic [SAMPLE_BITS+VALUE_BITS-1:0] samp_ext;
    logic [SAMPLE_BITS-1:0]   wdata;
    logic [VALUE_BITS+SAMPLE_BITS-1:0] mem_ext, min_ext, max_ext;
    logic [VALUE_BITS+SUM_BITS-1:0]    quo_ext;
    logic [SUM_BITS-1:0]      quotient;
    logic                     div_done;
    logic                     last_entry;
    logic [VALUE_BITS-1:0]    agg_value;

    assign len      = (hist_len_reg > DEPTH_L) ? DEPTH_L : hist_len_reg;
    assign wi_ext   = HIST_LEN_BITS'(wi_reg);
    assign wi_inc   = wi_ext + 1'b1;
    assign rp_inc   = HIST_LEN_BITS'(rp_reg) + 1'b1;
    assign held_now = wrapped_reg ? len : wi_ext;

    assign samp_ext = {{SAMPLE_BITS{1'b0}}, s_sample};
    assign wdata    = samp_ext[SAMPLE_BITS-1:0];
    assign mem_ext  = {{VALUE_BITS{1'b0}}, mem_q};
    assign min_ext  = {{VALUE_BITS{1'b0}}, min_reg};
    assign max_ext  = {{VALUE_BITS{1'b0}}, max_reg};
    assign quo_ext  = {{VALUE_BITS{1'b0}}, quotient};

    assign last_entry = (k_reg == held_reg - 1'b1);

    // store state: a length write clears the ring bookkeeping
    always_comb begin
        wi_next      = wi_reg;
        wrapped_next = wrapped_reg;
        seq_next     = seq_reg;
        if (cfg_wr_en && cfg_wr_index == REG_HISTORY_LENGTH) begin
            wi_next      = '0;
            wrapped_next = 1'b0;
            seq_next     = '0;
        end else if (cmd.store_put && len != '0) begin
            seq_next = seq_reg + 1'b1;
            if (wi_inc >= len) begin
                wi_next      = '0;
                wrapped_next = 1'b1;
            end else begin
                wi_next = wi_inc[IDX_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_len_reg <= '0;
            mode_reg     <= MODE_ALL;
            wi_reg       <= '0;
            wrapped_reg  <= 1'b0;
            seq_reg      <= '0;
        end else begin
            if (cfg_wr_en && cfg_wr_index == REG_HISTORY_LENGTH) begin
                hist_len_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_wr_index == REG_AGGREGATE_MODE) begin
                mode_reg <= agg_mode_t'(cfg_wr_data[MODE_BITS-1:0]);
            end
            wi_reg      <= wi_next;
            wrapped_reg <= wrapped_next;
            seq_reg     <= seq_next;
        end
    end

    // ring memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.store_put && len != '0) begin
            mem[wi_reg] <= wdata;
        end
        if (cmd.rd_issue) begin
            mem_q <= mem[rp_reg];
        end
    end

    // read pointer and entry counter
    always_comb begin
        rp_next = rp_reg;
        k_next  = k_reg;
        if (cmd.query_start) begin
            rp_next = wrapped_reg ? wi_reg : '0;
            k_next  = '0;
        end else if (cmd.ptr_advance) begin
            rp_next = (rp_inc >= len) ? '0 : rp_inc[IDX_BITS-1:0];
            k_next  = k_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        rp_reg <= rp_next;
        k_reg  <= k_next;
        if (cmd.query_start) begin
            held_reg <= held_now;
            fs_reg   <= seq_reg - SEQ_BITS'(held_now);
        end
        if (cmd.accum) begin
            if (k_reg == '0) begin
                sum_reg <= SUM_BITS'(mem_q);
                min_reg <= mem_q;
                max_reg <= mem_q;
            end else begin
                sum_reg <= sum_reg + SUM_BITS'(mem_q);
                if (mem_q < min_reg) begin
                    min_reg <= mem_q;
                end
                if (mem_q > max_reg) begin
                    max_reg <= mem_q;
                end
            end
        end
    end

    shra_div #(
        .SUM_BITS(SUM_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .dividend(sum_reg),
        .divisor (held_reg),
        .quotient(quotient),
        .done    (div_done)
    );

    always_comb begin
        case (mode_reg)
            MODE_AVG: agg_value = quo_ext[VALUE_BITS-1:0];
            MODE_MIN: agg_value = min_ext[VALUE_BITS-1:0];
            MODE_MAX: agg_value = max_ext[VALUE_BITS-1:0];
            default:  agg_value = mem_ext[VALUE_BITS-1:0];
        endcase
    end

    // output register: holds one result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_list || cmd.load_agg || cmd.load_empty) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_list) begin
            m_value_reg <= mem_ext[VALUE_BITS-1:0];
            m_fs_reg    <= fs_reg;
            m_held_reg  <= held_reg;
            m_last_reg  <= last_entry;
        end else if (cmd.load_agg) begin
            m_value_reg <= agg_value;
            m_fs_reg    <= fs_reg;
            m_held_reg  <= HIST_LEN_BITS'(1);
            m_last_reg  <= 1'b1;
        end else if (cmd.load_empty) begin
            m_value_reg <= '0;
            m_fs_reg    <= fs_reg;
            m_held_reg  <= '0;
            m_last_reg  <= 1'b1;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = m_value_reg;
    assign m_first_seq  = m_fs_reg;
    assign m_held_count = m_held_reg;
    assign m_last       = m_last_reg;

    assign status.held_zero  = (held_now == '0);
    assign status.last_entry = last_entry;
    assign status.div_done   = div_done;
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.mode       = mode_reg;

endmodule

/* rtl/shra_ctrl.sv */
// Controller state machine: sequences puts, the query walk, the divide and result loads.
// Depends on shra_pkg for states and the command and status structs.
module shra_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_func,
    output logic                 s_ready,
    input  shra_pkg::dp_status_t status,
    output shra_pkg::dp_cmd_t    cmd
);
    import shra_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign accept = s_valid && (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept && s_func == FUNC_PUT) begin
                    cmd.store_put = 1'b1;
                end else if (accept) begin
                    cmd.query_start = 1'b1;
                    state_next = status.held_zero ? ST_EMPTY : ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (status.mode == MODE_ALL) begin
                    state_next = ST_EMIT;
                end else begin
                    cmd.accum = 1'b1;
                    if (!status.last_entry) begin
                        cmd.ptr_advance = 1'b1;
                        state_next      = ST_READ;
                    end else if (status.mode == MODE_AVG) begin
                        state_next = ST_DIV_GO;
                    end else begin
                        state_next = ST_EMIT_AGG;
                    end
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.load_list = 1'b1;
                    if (status.last_entry) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.ptr_advance = 1'b1;
                        state_next      = ST_READ;
                    end
                end
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_EMIT_AGG;
                end
            end
            ST_EMIT_AGG: begin
                if (status.out_free) begin
                    cmd.load_agg = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (status.out_free) begin
                    cmd.load_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/sample_history_ring_aggregate.sv */
// Top level of the sample history ring with min, max and average query.
// Depends on shra_pkg and instantiates shra_ctrl and shra_dp (which holds shra_div).
//
//   channel  direction  handshake           payload
//   cfg      in         cfg_wr_en           cfg_wr_index, cfg_wr_data
//   s        in         s_valid / s_ready   s_func, s_sample
//   m        out        m_valid / m_ready   m_value, m_first_seq, m_held_count, m_last
//
// Sequencing: a put is stored when it is accepted; a query walks the held entries
// through the ring's registered read port, emitting each one when listing or
// accumulating it for an aggregate; an average then runs the bit-serial divide, and
// the block loads an aggregate or empty result.
// Reset: synchronous, active low; clears the control state, the ring bookkeeping and the
// sequence count. The ring memory itself is not cleared; only written entries are read.
// Stalls: s_ready is low while a query is in progress; a held result in the output
// register does not block a put or the start of the next query.
module sample_history_ring_aggregate #(
    parameter int DEPTH       = shra_pkg::DEPTH_DEF,
    parameter int SAMPLE_BITS = shra_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [shra_pkg::CFG_INDEX_BITS-1:0] cfg_wr_index,
    input  logic [shra_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_func,
    input  logic [shra_pkg::VALUE_BITS-1:0]     s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [shra_pkg::VALUE_BITS-1:0]     m_value,
    output logic [shra_pkg::SEQ_BITS-1:0]       m_first_seq,
    output logic [shra_pkg::HIST_LEN_BITS-1:0]  m_held_count,
    output logic                                m_last
);
    import shra_pkg::*;

    // command and status between the sequencer and the datapath
    dp_cmd_t    cmd;
    dp_status_t status;

    shra_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_func (s_func),
        .s_ready(s_ready),
        .status (status),
        .cmd    (cmd)
    );

    // ring store, walk pointer, accumulators, divider and output register
    shra_dp #(
        .DEPTH      (DEPTH),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_sample    (s_sample),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_value     (m_value),
        .m_first_seq (m_first_seq),
        .m_held_count(m_held_count),
        .m_last      (m_last),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

/* rtl/shra_checker.sv */
// Port-level checker for sample_history_ring_aggregate, attached by a bind below.
// Depends on shra_pkg for widths and the function codes.
module shra_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_func,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [shra_pkg::VALUE_BITS-1:0]     m_value,
    input logic [shra_pkg::HIST_LEN_BITS-1:0]  m_held_count,
    input logic                                m_last
);
    import shra_pkg::*;

    // a result not taken stays offered
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // an empty answer is a single zero result
    a_empty_answer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_held_count == '0 |-> m_last && m_value == '0)
        else $error("empty answer malformed");

    // only a listing has results before the last, and it holds at least two samples
    a_list_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_held_count > HIST_LEN_BITS'(1))
        else $error("non-final result with bad count");

    // a query request blocks the input channel in the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_QUERY |=> !s_ready)
        else $error("request accepted during a query");

endmodule

bind sample_history_ring_aggregate shra_checker u_shra_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_func      (s_func),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_value     (m_value),
    .m_held_count(m_held_count),
    .m_last      (m_last)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sample_history_ring_aggregate: puts and queries against
// a cycle-free history predictor, under varied ready/valid idling. Depends on shra_pkg.
module testbench;
    import shra_pkg::*;

    localparam int RING_SLOTS   = DEPTH_DEF;
    // Worst query: a full listing of every ring slot plus the divider, with margin
    localparam int SETTLE_TICKS = 3 * RING_SLOTS + SAMPLE_BITS_DEF + 32;

    typedef struct {
        logic                  func;
        logic [VALUE_BITS-1:0] sample;
        bit                    drain_first;  // hold until every answer is back
    } history_request_t;

    typedef struct {
        logic [VALUE_BITS-1:0]    value;
        logic [SEQ_BITS-1:0]      first_seq;
        logic [HIST_LEN_BITS-1:0] held_count;
        logic                     last;
    } history_answer_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_func = FUNC_PUT;
    logic [VALUE_BITS-1:0]     s_sample = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [VALUE_BITS-1:0]     m_value;
    logic [SEQ_BITS-1:0]       m_first_seq;
    logic [HIST_LEN_BITS-1:0]  m_held_count;
    logic                      m_last;

    // Traffic between the stimulus, the driver and the monitor
    history_request_t pending_requests[$];
    history_answer_t  awaited_answers[$];
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      mismatches = 0;
    int unsigned      puts_taken = 0;
    int unsigned      queries_taken = 0;
    int unsigned      answers_seen = 0;
    int unsigned      settings_written = 0;

    // Predicted history state, kept in step with the block
    logic [VALUE_BITS-1:0]    hist_ring[RING_SLOTS];
    int unsigned              hist_wr_idx = 0;
    bit                       hist_wrapped = 0;
    logic [SEQ_BITS-1:0]      hist_seq = '0;
    logic [HIST_LEN_BITS-1:0] hist_len = '0;
    agg_mode_t                hist_mode = MODE_ALL;

    sample_history_ring_aggregate dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_first_seq  (m_first_seq),
        .m_held_count (m_held_count),
        .m_last       (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Apply one accepted request to the predicted history and queue the answers it owes.
    function automatic void ring_apply_request(logic func, logic [VALUE_BITS-1:0] smp);
        int unsigned     eff;
        int unsigned     held;
        int unsigned     start;
        int unsigned     idx;
        logic [63:0]     sum;
        logic [31:0]     lo;
        logic [31:0]     hi;
        logic [31:0]     res;
        logic [31:0]     fs;
        history_answer_t ans;
        eff = (hist_len > RING_SLOTS) ? RING_SLOTS : hist_len;
        if (func == FUNC_PUT) begin
            // A zero length drops the sample and leaves the count alone
            if (eff != 0) begin
                idx = (hist_wr_idx >= eff) ? 0 : hist_wr_idx;
                hist_ring[idx] = smp;
                idx++;
                if (idx >= eff) begin
                    idx = 0;
                    hist_wrapped = 1'b1;
                end
                hist_wr_idx = idx;
                hist_seq = hist_seq + 1;
            end
            return;
        end
        held = hist_wrapped ? eff : hist_wr_idx;
        if (held > eff) held = eff;
        fs = hist_seq - held;
        if (held == 0) begin
            // Empty store: a single zero answer that still carries the sequence
            ans = '{value: '0, first_seq: fs, held_count: '0, last: 1'b1};
            awaited_answers = {awaited_answers, ans};
            return;
        end
        start = hist_wrapped ? hist_wr_idx : 0;
        if (start >= eff) start = 0;
        sum = '0;
        lo = '0;
        hi = '0;
        for (int unsigned k = 0; k < held; k++) begin
            idx = start + k;
            if (idx >= eff) idx -= eff;
            if (hist_mode == MODE_ALL) begin
                ans = '{value: hist_ring[idx], first_seq: fs,
                        held_count: held[HIST_LEN_BITS-1:0], last: (k + 1 == held)};
                awaited_answers = {awaited_answers, ans};
            end
            sum += {32'd0, hist_ring[idx]};
            if (k == 0 || hist_ring[idx] < lo) lo = hist_ring[idx];
            if (k == 0 || hist_ring[idx] > hi) hi = hist_ring[idx];
        end
        if (hist_mode != MODE_ALL) begin
            case (hist_mode)
                MODE_AVG: begin
                    sum = sum / held;
                    res = sum[31:0];
                end
                MODE_MIN: res = lo;
                default:  res = hi;
            endcase
            ans = '{value: res, first_seq: fs, held_count: 7'd1, last: 1'b1};
            awaited_answers = {awaited_answers, ans};
        end
    endfunction

    // Driver: present the next pending request, holding it steady until it is taken.
    always @(posedge aclk) begin
        history_request_t nxt;
        bit               present;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                ring_apply_request(s_func, s_sample);
                if (s_func == FUNC_PUT) puts_taken++;
                else queries_taken++;
            end
            if (!s_valid || s_ready) begin
                present = 1'b0;
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    // Pause the sender until the history has answered everything
                    present = !pending_requests[0].drain_first ||
                              awaited_answers.size() == 0;
                end
                if (present) begin
                    nxt = pending_requests.pop_front();
                    s_valid  <= 1'b1;
                    s_func   <= nxt.func;
                    s_sample <= nxt.sample;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare every taken answer with the oldest prediction.
    always @(posedge aclk) begin
        history_answer_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                answers_seen++;
                if (awaited_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected answer: value=%h first_seq=%h held=%0d last=%b",
                                 m_value, m_first_seq, m_held_count, m_last);
                end else begin
                    want = awaited_answers.pop_front();
                    if (m_value !== want.value || m_first_seq !== want.first_seq ||
                        m_held_count !== want.held_count || m_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("answer mismatch: expected value=%h first_seq=%h %s",
                                     want.value, want.first_seq, "");
                            $display("    expected held=%0d last=%b",
                                     want.held_count, want.last);
                            $display("    got value=%h first_seq=%h held=%0d last=%b",
                                     m_value, m_first_seq, m_held_count, m_last);
                        end
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic queue_request(logic func, logic [VALUE_BITS-1:0] smp, bit drain = 1'b0);
        history_request_t req;
        req = '{func: func, sample: smp, drain_first: drain};
        pending_requests = {pending_requests, req};
    endtask

    // Wait until nothing is queued, driven or owed, then let the block settle.
    task automatic wait_quiet();
        do @(negedge aclk);
        while (pending_requests.size() != 0 || s_valid || awaited_answers.size() != 0);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    // Write one register while idle; mirror its effect on the predicted history.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_HISTORY_LENGTH) begin
            // A length write wipes the ring bookkeeping and the sequence count
            hist_len     = data;
            hist_wr_idx  = 0;
            hist_wrapped = 1'b0;
            hist_seq     = '0;
        end else begin
            hist_mode = agg_mode_t'(data[MODE_BITS-1:0]);
        end
        settings_written++;
    endtask

    function automatic logic [VALUE_BITS-1:0] pick_sample(int unsigned style);
        case (style)
            0: return '1;
            1: begin
                case ($urandom_range(3))
                    0: return '0;
                    1: return '1;
                    2: return 32'h8000_0000;
                    default: return 32'h7fff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Queue bursts of puts, each closed by a query; bursts range from none to past a wrap.
    task automatic run_batch(int unsigned budget);
        int unsigned made;
        int unsigned burst;
        int unsigned style;
        int unsigned eff;
        made = 0;
        eff = (hist_len > RING_SLOTS) ? RING_SLOTS : hist_len;
        while (made < budget) begin
            burst = $urandom_range(1) ? $urandom_range(3) : $urandom_range(eff + 4);
            style = $urandom_range(5);
            for (int unsigned k = 0; k < burst && made + 1 < budget; k++) begin
                queue_request(FUNC_PUT, pick_sample(style));
                made++;
            end
            queue_request(FUNC_QUERY, $urandom, ($urandom_range(19) == 0));
            made++;
        end
        wait_quiet();
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] len_plan[8];
        int unsigned              budget_plan[8];
        len_plan    = '{7'd64, 7'd3, 7'd100, 7'd1, 7'd7, 7'd127, 7'd2, 7'd16};
        budget_plan = '{70, 18, 40, 14, 24, 40, 14, 30};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Length zero out of reset: the put is dropped and the query answers empty
        queue_request(FUNC_PUT, 32'h1234_5678);
        queue_request(FUNC_QUERY, '0);
        wait_quiet();

        // Single-slot history: empty answer, then the newer sample replaces the older
        write_reg(REG_HISTORY_LENGTH, 7'd1);
        queue_request(FUNC_QUERY, '1);
        queue_request(FUNC_PUT, '0);
        queue_request(FUNC_PUT, '1);
        queue_request(FUNC_QUERY, '0);
        wait_quiet();

        // Three slots, four puts: the ring wraps; the second query waits for the first
        // listing to drain, then every aggregate over the extremes
        write_reg(REG_HISTORY_LENGTH, 7'd3);
        queue_request(FUNC_PUT, '1);
        queue_request(FUNC_PUT, 32'h8000_0000);
        queue_request(FUNC_PUT, 32'h0000_0001);
        queue_request(FUNC_PUT, 32'h7fff_ffff);
        queue_request(FUNC_QUERY, '0);
        queue_request(FUNC_QUERY, '0, 1'b1);
        wait_quiet();
        for (int m = MODE_AVG; m <= MODE_MAX; m++) begin
            write_reg(REG_AGGREGATE_MODE, CFG_DATA_BITS'(m));
            queue_request(FUNC_QUERY, '0);
            wait_quiet();
        end

        // Random bursts across lengths, modes and idling patterns
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            write_reg(REG_HISTORY_LENGTH, len_plan[p]);
            for (int c = 0; c < 2; c++) begin
                write_reg(REG_AGGREGATE_MODE, CFG_DATA_BITS'((2 * p + c) % 4));
                run_batch(budget_plan[p] / 2);
            end
        end

        mismatches += awaited_answers.size();
        $display("covered %0d puts and %0d queries, %0d answers checked, %0d register writes",
                 puts_taken, queries_taken, answers_seen, settings_written);
        $display("lengths 0 to 127 (saturating at %0d), all four answer modes", RING_SLOTS);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #1_000_000;
        $display("timeout with %0d requests queued and %0d answers owed",
                 pending_requests.size(), awaited_answers.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule
